FILE: hw/rtl/shamh_pkg.sv
// ----------------------------------------------------------------------------
// shamh_pkg
// Shared types, constants and round functions for the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package shamh_pkg;

    localparam int unsigned NumRounds  = 64;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenPos     = 56;   // first byte of the length field

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic       init;     // reload initial hash
        logic       load;     // working vars <= hash
        logic       step;     // one compression round
        logic       add;      // hash += working vars
        logic [5:0] rnd;      // current round
        logic [2:0] rd_idx;   // digest word to show
    } t_core_ctl;

    typedef struct packed {
        logic       push;       // take one byte
        logic       word_done;  // byte completes a word
        logic       step;       // expand schedule by one word
        logic [7:0] data;
    } t_sched_ctl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

FILE: hw/rtl/shamh_sched.sv
// ----------------------------------------------------------------------------
// shamh_sched
// Byte packer and message schedule: a 16-word window that fills with
// big-endian words and then expands one schedule word per round.
// ----------------------------------------------------------------------------
module shamh_sched (
    input  logic                   i_clk,
    input  shamh_pkg::t_sched_ctl  i_ctl,
    output logic [31:0]            o_w
);

    logic [23:0] r_acc;
    logic [31:0] r_win [16];
    logic [31:0] n_word;
    logic        shift_en;

    // W[t] sits in r_win[0]; the window holds W[t..t+15]
    always_comb begin
        if (i_ctl.step) begin
            n_word = shamh_pkg::small_sigma1(r_win[14]) + r_win[9]
                   + shamh_pkg::small_sigma0(r_win[1]) + r_win[0];
        end else begin
            n_word = {r_acc, i_ctl.data};
        end
        shift_en = i_ctl.step || (i_ctl.push && i_ctl.word_done);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_acc <= {r_acc[15:0], i_ctl.data};
        end
        if (shift_en) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= n_word;
        end
    end

    assign o_w = r_win[0];

endmodule

FILE: hw/rtl/shamh_core.sv
// ----------------------------------------------------------------------------
// shamh_core
// Compression round unit: working variables a..h, one round per cycle,
// and the chaining hash with its final add.
// ----------------------------------------------------------------------------
module shamh_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  shamh_pkg::t_core_ctl  i_ctl,
    input  logic [31:0]           i_w,
    output logic [31:0]           o_hash_word
);

    logic [31:0] r_hash [8];
    logic [31:0] r_var  [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb begin
        ch  = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        maj = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        t1  = r_var[7] + shamh_pkg::big_sigma1(r_var[4]) + ch
            + shamh_pkg::round_k(i_ctl.rnd) + i_w;
        t2  = shamh_pkg::big_sigma0(r_var[0]) + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= shamh_pkg::InitHash[i];
            end
        end else if (i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= shamh_pkg::InitHash[i];
            end
        end else if (i_ctl.add) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= r_hash[i] + r_var[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) begin
                r_var[i] <= r_hash[i];
            end
        end else if (i_ctl.step) begin
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= r_var[3] + t1;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= t1 + t2;
        end
    end

    assign o_hash_word = r_hash[i_ctl.rd_idx];

endmodule

FILE: hw/rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream: byte packing, padding sequencer, one round per
// cycle through a shared round unit, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// Compression: the 64th byte of a block starts 64 rounds on the round unit, then
//   one hash add. End of message: padding feeds one byte per cycle to the packer
//   outside compressions (up to 64 per block, one or two blocks), then 8 digest
//   words follow, one per cycle while i_stall is low.
// Throughput: 1 byte per cycle while idle between blocks; o_stall is high otherwise.
// Reset: synchronous, active low; initial hash loaded, length and position cleared.
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state      r_state,    n_state;
    logic [5:0]  r_pos,      n_pos;
    logic [63:0] r_bitlen,   n_bitlen;
    logic [5:0]  r_rnd,      n_rnd;
    logic [2:0]  r_oidx,     n_oidx;
    logic        r_pend,     n_pend;      // end of message seen, digest owed
    logic        r_pad_first, n_pad_first;
    logic        r_len_ok,   n_len_ok;    // length field goes in this block
    logic        r_last_blk, n_last_blk;

    logic        feed;
    logic [7:0]  feed_byte;
    logic [7:0]  pad_byte;
    logic        blk_full;

    shamh_pkg::t_core_ctl  core_ctl;
    shamh_pkg::t_sched_ctl sched_ctl;
    logic [31:0]           w;
    logic [31:0]           hash_word;

    always_comb begin
        if (r_pad_first) begin
            pad_byte = shamh_pkg::PadByte;
        end else if (r_len_ok && r_pos >= 6'(shamh_pkg::LenPos)) begin
            pad_byte = r_bitlen[{~r_pos[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end

        feed = (r_state == S_PAD) ||
               (r_state == S_IDLE && i_valid && i_byte_present);
        feed_byte = (r_state == S_PAD) ? pad_byte : i_data_byte;
        blk_full  = feed && (r_pos == 6'(shamh_pkg::BlockBytes - 1));

        sched_ctl.push      = feed;
        sched_ctl.word_done = (r_pos[1:0] == 2'b11);
        sched_ctl.step      = (r_state == S_ROUND);
        sched_ctl.data      = feed_byte;

        core_ctl.init   = (r_state == S_OUT) && !i_stall && (r_oidx == 3'd7);
        core_ctl.load   = blk_full;
        core_ctl.step   = (r_state == S_ROUND);
        core_ctl.add    = (r_state == S_ADD);
        core_ctl.rnd    = r_rnd;
        core_ctl.rd_idx = r_oidx;
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_bitlen    = r_bitlen;
        n_rnd       = r_rnd;
        n_oidx      = r_oidx;
        n_pend      = r_pend;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_last_blk  = r_last_blk;

        if (feed) begin
            n_pos = r_pos + 6'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_byte_present) begin
                        n_bitlen = r_bitlen + 64'd8;
                    end
                    if (i_end_of_message) begin
                        n_pend      = 1'b1;
                        n_pad_first = 1'b1;
                        n_len_ok    = 1'b0;
                    end
                    if (blk_full) begin
                        n_state    = S_ROUND;
                        n_rnd      = '0;
                        n_last_blk = 1'b0;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_pad_first = 1'b0;
                if (r_pad_first && r_pos < 6'(shamh_pkg::LenPos)) begin
                    n_len_ok = 1'b1;
                end
                if (blk_full) begin
                    // a pad block without the length pushes it to the next one
                    n_last_blk = r_len_ok;
                    n_len_ok   = 1'b1;
                    n_state    = S_ROUND;
                    n_rnd      = '0;
                end
            end
            S_ROUND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'(shamh_pkg::NumRounds - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_last_blk) begin
                    n_state = S_OUT;
                    n_oidx  = '0;
                end else if (r_pend) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_state    = S_IDLE;
                        n_pos      = '0;
                        n_bitlen   = '0;
                        n_pend     = 1'b0;
                        n_last_blk = 1'b0;
                        n_len_ok   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_bitlen    <= '0;
            r_rnd       <= '0;
            r_oidx      <= '0;
            r_pend      <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_last_blk  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_bitlen    <= n_bitlen;
            r_rnd       <= n_rnd;
            r_oidx      <= n_oidx;
            r_pend      <= n_pend;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_last_blk  <= n_last_blk;
        end
    end

    shamh_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w)
    );

    shamh_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (core_ctl),
        .i_w         (w),
        .o_hash_word (hash_word)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = hash_word;
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

endmodule
